// ===== rtl/sha256_pkg.sv =====
// sha256_pkg: constants and round functions for the sha-256 stream hasher
// no dependencies
package sha256_pkg;

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    begin
      unique case (t)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/sha256_stream_hasher_unit.sv =====
// sha256_stream_hasher_unit: sha-256 over a byte stream, one round per cycle
// depends on sha256_pkg
//
//  channel | ports                                       | direction
//  in      | in_valid in_stall in_data_byte in_is_last in_no_data | into block
//  out     | out_valid out_stall out_digest_word0..3      | out of block
//
// a plain byte is simply buffered; a byte that fills the block starts a
// compression of load, round and add steps, set by the single shared round unit
// closing writes the pad bytes one by one and runs one or two compressions,
// then ST_OUT raises out_valid and the digest waits until out_stall drops
// reset (rst_n low, synchronous) restores the initial chaining words
// in_stall is high whenever the block is not idle or a digest is pending
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  input  logic        in_no_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word0,
  output logic [63:0] out_digest_word1,
  output logic [63:0] out_digest_word2,
  output logic [63:0] out_digest_word3
);

  logic [2:0]   state_r;
  logic [31:0]  buf_r [16];
  logic [5:0]   fill_r;
  logic [60:0]  total_r;
  logic [255:0] h_r;
  logic [31:0]  va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r;
  logic [31:0]  w_r [16];
  logic [6:0]   cnt_r;
  logic         fin_r;     // closing in progress
  logic         lenblk_r;  // current compression carries the length
  logic         pad_done_r;  // 0x80 byte already placed
  logic         out_valid_r;
  logic [31:0]  rd_word_r;

  logic         acc;
  logic [3:0]   ti;
  logic [3:0]   rd_addr;
  logic [31:0]  x2, x15, s0, s1, wnew, wcur, t1, t2;

  assign in_stall  = (state_r != sha256_pkg::ST_IDLE) || out_valid_r;
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_digest_word0 = h_r[255:192];
  assign out_digest_word1 = h_r[191:128];
  assign out_digest_word2 = h_r[127:64];
  assign out_digest_word3 = h_r[63:0];

  assign ti   = cnt_r[3:0];
  assign x2   = w_r[ti - 4'd2];
  assign x15  = w_r[ti - 4'd15];
  assign s1   = sha256_pkg::ror(x2, 17) ^ sha256_pkg::ror(x2, 19) ^ (x2 >> 10);
  assign s0   = sha256_pkg::ror(x15, 7) ^ sha256_pkg::ror(x15, 18) ^ (x15 >> 3);
  assign wnew = s1 + w_r[ti - 4'd7] + s0 + w_r[ti];
  assign wcur = (cnt_r < 7'd16) ? rd_word_r : wnew;
  assign t1 = vh_r + (sha256_pkg::ror(ve_r, 6) ^ sha256_pkg::ror(ve_r, 11)
              ^ sha256_pkg::ror(ve_r, 25)) + ((ve_r & vf_r) ^ (~ve_r & vg_r))
              + sha256_pkg::round_k(cnt_r[5:0]) + wcur;
  assign t2 = (sha256_pkg::ror(va_r, 2) ^ sha256_pkg::ror(va_r, 13)
              ^ sha256_pkg::ror(va_r, 22))
              + ((va_r & vb_r) ^ (va_r & vc_r) ^ (vb_r & vc_r));

  // buffer memory: one write and one registered word read per cycle
  logic        bw_en;
  logic [5:0]  bw_addr;
  logic [7:0]  bw_data;
  logic [63:0] lenbits;
  assign lenbits = {total_r, 3'b000};

  always_comb begin
    bw_en = 1'b0;
    bw_addr = fill_r;
    bw_data = in_data_byte;
    if (acc && !in_no_data) begin
      bw_en = 1'b1;
    end else if (state_r == sha256_pkg::ST_PAD) begin
      bw_en = 1'b1;
      if (lenblk_r && fill_r >= sha256_pkg::LEN_POS) begin
        bw_data = lenbits[8'd63 - {fill_r[2:0], 3'b000} -: 8];
      end else begin
        bw_data = cnt_r[0] ? sha256_pkg::PAD_BYTE : 8'h00;
      end
    end
  end

  // word t is read at the edge where cnt_r = t-1; word 0 is read in ST_LOAD
  assign rd_addr = (state_r == sha256_pkg::ST_RND) ? cnt_r[3:0] + 4'd1 : 4'd0;

  always_ff @(posedge clk) begin
    if (bw_en) buf_r[bw_addr[5:2]][{~bw_addr[1:0], 3'b000} +: 8] <= bw_data;
    rd_word_r <= buf_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha256_pkg::ST_IDLE;
      fill_r <= '0;
      total_r <= '0;
      h_r <= sha256_pkg::H_INIT;
      cnt_r <= '0;
      fin_r <= 1'b0;
      lenblk_r <= 1'b0;
      pad_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
        h_r <= sha256_pkg::H_INIT;
      end
      unique case (state_r)
        sha256_pkg::ST_IDLE: begin
          if (acc) begin
            if (in_no_data) begin
              fin_r <= 1'b1;
              cnt_r <= 7'd1;  // first pad byte is 0x80
              lenblk_r <= 1'b0;
              state_r <= sha256_pkg::ST_PAD;
            end else begin
              fill_r <= fill_r + 6'd1;
              total_r <= total_r + 61'd1;
              fin_r <= in_is_last;
              if (fill_r == 6'd63) begin
                cnt_r <= '0;
                state_r <= sha256_pkg::ST_LOAD;
              end else if (in_is_last) begin
                cnt_r <= 7'd1;
                lenblk_r <= 1'b0;
                state_r <= sha256_pkg::ST_PAD;
              end
            end
          end
        end
        sha256_pkg::ST_PAD: begin
          // cnt_r[0] marks the 0x80 byte; it clears after the first write
          cnt_r <= '0;
          pad_done_r <= 1'b1;
          fill_r <= fill_r + 6'd1;
          if (!lenblk_r && fill_r == 6'd55) lenblk_r <= 1'b1;
          if (fill_r == 6'd63) begin
            state_r <= sha256_pkg::ST_LOAD;
          end
        end
        sha256_pkg::ST_LOAD: begin
          // prime the registered read in the cycle before the rounds start
          {va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r} <= h_r;
          state_r <= sha256_pkg::ST_RND;
          cnt_r <= '0;
          fill_r <= '0;
        end
        sha256_pkg::ST_RND: begin
          if (cnt_r < 7'd16) w_r[ti] <= rd_word_r;
          else w_r[ti] <= wnew;
          vh_r <= vg_r; vg_r <= vf_r; vf_r <= ve_r; ve_r <= vd_r + t1;
          vd_r <= vc_r; vc_r <= vb_r; vb_r <= va_r; va_r <= t1 + t2;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) state_r <= sha256_pkg::ST_ADD;
        end
        sha256_pkg::ST_ADD: begin
          h_r <= {h_r[255:224] + va_r, h_r[223:192] + vb_r, h_r[191:160] + vc_r,
                  h_r[159:128] + vd_r, h_r[127:96] + ve_r, h_r[95:64] + vf_r,
                  h_r[63:32] + vg_r, h_r[31:0] + vh_r};
          cnt_r <= '0;
          if (!fin_r) begin
            state_r <= sha256_pkg::ST_IDLE;
          end else if (lenblk_r) begin
            state_r <= sha256_pkg::ST_OUT;
          end else begin
            // fresh block for the length; it starts with 0x80 only if not yet placed
            cnt_r <= {6'd0, !pad_done_r};
            state_r <= sha256_pkg::ST_PAD;
          end
        end
        sha256_pkg::ST_OUT: begin
          out_valid_r <= 1'b1;
          fin_r <= 1'b0;
          lenblk_r <= 1'b0;
          pad_done_r <= 1'b0;
          fill_r <= '0;
          total_r <= '0;
          state_r <= sha256_pkg::ST_IDLE;
        end
        default: state_r <= sha256_pkg::ST_IDLE;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256_pkg::ST_RND) |-> in_stall)
    else $error("input taken during rounds");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(h_r)))
    else $error("digest changed while stalled");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256_pkg::ST_RND && cnt_r == 7'd63) |=> (state_r == sha256_pkg::ST_ADD))
    else $error("round count overrun");

endmodule
